@@ design/sjis_char_code_decoder_unit_macros.svh @@
// Assertion macros shared by the checker of the Shift-JIS decoder.
// Both macros sample on the rising edge of clk_i and are disabled while rst_ni is low.
`ifndef SJIS_CHAR_CODE_DECODER_UNIT_MACROS_SVH
`define SJIS_CHAR_CODE_DECODER_UNIT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define SJISDEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never holds at any clock edge outside reset.
`define SJISDEC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ design/sjisdec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sjisdec_pkg;

  localparam logic [7:0]  LeadLo     = 8'h81;
  localparam logic [7:0]  LeadMidHi  = 8'h9F;
  localparam logic [7:0]  LeadUpLo   = 8'hE0;
  localparam logic [7:0]  LeadUpHi   = 8'hFC;
  localparam logic [7:0]  LeadShift  = 8'h40;
  localparam logic [7:0]  TrailLo    = 8'h40;
  localparam logic [7:0]  TrailHi    = 8'hFC;
  localparam logic [7:0]  TrailGap   = 8'h7F;
  localparam logic [7:0]  TrailStep  = 8'h80;
  localparam logic [7:0]  TrailSplit = 8'h9E;
  localparam logic [7:0]  JisBias    = 8'h21;
  localparam logic [6:0]  KuTenBias  = 7'h20;
  localparam logic [7:0]  KanaLo     = 8'hA1;
  localparam logic [7:0]  KanaHi     = 8'hFE;
  localparam logic [7:0]  EucKanaPfx = 8'h8E;
  localparam logic [15:0] EucSet     = 16'h8080;
  localparam logic [7:0]  EndByte    = 8'h00;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_stage_t;

  typedef struct packed {
    logic [15:0] sjis_code;
    logic [15:0] jis_code;
    logic [15:0] euc_code;
    logic        is_double;
    logic [6:0]  ku_row;
    logic [6:0]  ten_cell;
  } result_t;

  function automatic logic is_lead(input logic [7:0] b);
    return (b >= LeadLo) && ((b <= LeadMidHi) || ((b >= LeadUpLo) && (b <= LeadUpHi)));
  endfunction

  function automatic logic is_trail(input logic [7:0] b);
    return (b >= TrailLo) && (b <= TrailHi) && (b != TrailGap);
  endfunction

  function automatic logic [15:0] to_jis(input logic [7:0] lead, input logic [7:0] trail);
    logic [7:0] hi;
    logic [7:0] lo;
    logic       carry;
    hi    = (lead >= LeadUpLo) ? lead - LeadShift : lead;
    hi    = hi - LeadLo;
    lo    = (trail >= TrailStep) ? trail - 8'd1 : trail;
    carry = (lo >= TrailSplit);
    lo    = carry ? lo - TrailSplit : lo - TrailLo;
    hi    = {hi[6:0], 1'b0} + {7'd0, carry} + JisBias;
    lo    = lo + JisBias;
    return {hi, lo};
  endfunction

endpackage

`default_nettype wire

@@ design/sjis_char_code_decoder_unit.sv @@
// A character's last byte is registered at the input, then its result in the result register.
// Throughput: one byte per cycle while the consumer keeps up; a waiting result stalls the input
// as soon as the staged byte would produce another transaction.
// The rate is set by the single conversion pass between the input and result registers.
// Reset (rst_ni, asynchronous, active low) empties both registers and drops any held lead byte.
`timescale 1ns / 1ps
`default_nettype none

module sjis_char_code_decoder_unit import sjisdec_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      sjis_code_o,
  output logic [15:0]      jis_code_o,
  output logic [15:0]      euc_code_o,
  output logic             is_double_o,
  output logic [6:0]       ku_row_o,
  output logic [6:0]       ten_cell_o
);

  byte_stage_t stage;
  result_t     conv_result;
  result_t     out_result;
  logic        has_result;
  logic        out_free;
  logic        fire;

  assign fire = stage.valid && (!has_result || out_free);

  sjisdec_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .take_i     (fire),
    .stage_o    (stage)
  );

  sjisdec_convert u_convert (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stage_i      (stage),
    .fire_i       (fire),
    .has_result_o (has_result),
    .result_o     (conv_result)
  );

  sjisdec_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && has_result),
    .result_i    (conv_result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign sjis_code_o = out_result.sjis_code;
  assign jis_code_o  = out_result.jis_code;
  assign euc_code_o  = out_result.euc_code;
  assign is_double_o = out_result.is_double;
  assign ku_row_o    = out_result.ku_row;
  assign ten_cell_o  = out_result.ten_cell;

endmodule

`default_nettype wire

@@ design/sjisdec_in_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sjisdec_in_stage import sjisdec_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        take_i,
  output byte_stage_t      stage_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] data_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_byte_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

`default_nettype wire

@@ design/sjisdec_convert.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sjisdec_convert import sjisdec_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire byte_stage_t stage_i,
  input  wire logic        fire_i,
  output logic             has_result_o,
  output result_t          result_o
);

  logic       lead_pending_q;
  logic       lead_pending_d;
  logic [7:0] lead_byte_q;
  logic [7:0] lead_byte_d;
  logic [7:0] single_byte;
  logic [15:0] jis;

  assign jis = to_jis(lead_byte_q, stage_i.data);

  always_comb begin
    lead_pending_d = lead_pending_q;
    lead_byte_d    = lead_byte_q;
    has_result_o   = 1'b0;
    result_o       = '0;
    single_byte    = lead_pending_q ? lead_byte_q : stage_i.data;
    if (stage_i.data == EndByte) begin
      lead_pending_d = 1'b0;
      lead_byte_d    = EndByte;
    end else if (!lead_pending_q && is_lead(stage_i.data)) begin
      lead_pending_d = 1'b1;
      lead_byte_d    = stage_i.data;
    end else if (lead_pending_q && is_trail(stage_i.data)) begin
      lead_pending_d     = 1'b0;
      has_result_o       = stage_i.valid;
      result_o.sjis_code = {lead_byte_q, stage_i.data};
      result_o.jis_code  = jis;
      result_o.euc_code  = jis | EucSet;
      result_o.is_double = 1'b1;
      result_o.ku_row    = jis[14:8] - KuTenBias;
      result_o.ten_cell  = jis[6:0] - KuTenBias;
    end else begin
      lead_pending_d     = 1'b0;
      has_result_o       = stage_i.valid;
      result_o.sjis_code = {8'd0, single_byte};
      result_o.jis_code  = {8'd0, single_byte};
      result_o.euc_code  = ((single_byte >= KanaLo) && (single_byte <= KanaHi)) ?
                           {EucKanaPfx, single_byte} : {8'd0, single_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pending_q <= 1'b0;
      lead_byte_q    <= 8'd0;
    end else if (fire_i) begin
      lead_pending_q <= lead_pending_d;
      lead_byte_q    <= lead_byte_d;
    end
  end

endmodule

`default_nettype wire

@@ design/sjisdec_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sjisdec_out_stage import sjisdec_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire result_t     result_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output result_t          result_o
);

  logic    valid_q;
  logic    valid_d;
  result_t result_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

@@ design/sjisdec_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "sjis_char_code_decoder_unit_macros.svh"

module sjisdec_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [7:0]  in_byte_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] sjis_code_o,
  input wire logic [15:0] jis_code_o,
  input wire logic [15:0] euc_code_o,
  input wire logic        is_double_o,
  input wire logic [6:0]  ku_row_o,
  input wire logic [6:0]  ten_cell_o
);

  `SJISDEC_ASSERT(a_stall_hold, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sjis_code_o) && $stable(euc_code_o) && $stable(is_double_o)), "Result changed while stalled")

  `SJISDEC_ASSERT_NEVER(a_single_fields, out_valid_o && !is_double_o && (ku_row_o != 7'd0 || ten_cell_o != 7'd0 || jis_code_o != sjis_code_o || sjis_code_o[15:8] != 8'd0), "Single-byte transaction carries two-byte fields")

  `SJISDEC_ASSERT_NEVER(a_double_euc, out_valid_o && is_double_o && (euc_code_o != (jis_code_o | 16'h8080) || sjis_code_o[15:8] < 8'h81 || sjis_code_o[7:0] < 8'h40 || sjis_code_o[7:0] == 8'h7F), "Two-byte transaction is inconsistent")

  `SJISDEC_ASSERT_NEVER(a_no_zero_result, out_valid_o && sjis_code_o == 16'd0, "End-of-string byte produced a transaction")

endmodule

bind sjis_char_code_decoder_unit sjisdec_checker u_sjisdec_checker (.*);

`default_nettype wire

@@ test/sjis_char_code_decoder_unit_test.sv @@
`timescale 1ns / 1ps

module sjis_char_code_decoder_unit_test;
  import sjisdec_pkg::*;

  class sjis_char_scoreboard;
    bit          lead_held;
    bit [7:0]    held_lead;
    result_t     expected_q[$];
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned chars_checked;
    int unsigned double_chars;

    function bit starts_double(bit [7:0] b);
      return (b >= 8'h81) && ((b <= 8'h9F) || ((b >= 8'hE0) && (b <= 8'hFC)));
    endfunction

    function bit ends_double(bit [7:0] b);
      return (b >= 8'h40) && (b <= 8'hFC) && (b != 8'h7F);
    endfunction

    function result_t decode_pair(bit [7:0] lead, bit [7:0] trail);
      bit [7:0] row;
      bit [7:0] t;
      bit [7:0] hi;
      bit [7:0] lo;
      result_t  r;
      row = (lead >= 8'hE0) ? lead - 8'hC1 : lead - 8'h81;
      t   = (trail >= 8'h80) ? trail - 8'd1 : trail;
      if (t >= 8'h9E) begin
        hi = {row[6:0], 1'b0} + 8'h22;
        lo = t - 8'h7D;
      end else begin
        hi = {row[6:0], 1'b0} + 8'h21;
        lo = t - 8'h1F;
      end
      r.sjis_code = {lead, trail};
      r.jis_code  = {hi, lo};
      r.euc_code  = {hi, lo} | 16'h8080;
      r.is_double = 1'b1;
      r.ku_row    = hi[6:0] - 7'h20;
      r.ten_cell  = lo[6:0] - 7'h20;
      return r;
    endfunction

    function result_t decode_single(bit [7:0] b);
      result_t r;
      r.sjis_code = {8'h00, b};
      r.jis_code  = {8'h00, b};
      r.euc_code  = ((b >= 8'hA1) && (b <= 8'hFE)) ? {8'h8E, b} : {8'h00, b};
      r.is_double = 1'b0;
      r.ku_row    = 7'd0;
      r.ten_cell  = 7'd0;
      return r;
    endfunction

    function void note_byte(bit [7:0] b);
      bytes_seen++;
      if (b == 8'h00) begin
        lead_held = 1'b0;
        held_lead = 8'h00;
      end else if (!lead_held && starts_double(b)) begin
        lead_held = 1'b1;
        held_lead = b;
      end else if (lead_held) begin
        lead_held = 1'b0;
        if (ends_double(b)) expected_q.push_back(decode_pair(held_lead, b));
        else expected_q.push_back(decode_single(held_lead));
      end else begin
        expected_q.push_back(decode_single(b));
      end
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual sjis 0x%0h", $time,
                 got.sjis_code);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      chars_checked++;
      if (exp_r.is_double) double_chars++;
      compare_field("sjis_code", exp_r.sjis_code, got.sjis_code);
      compare_field("jis_code", exp_r.jis_code, got.jis_code);
      compare_field("euc_code", exp_r.euc_code, got.euc_code);
      compare_field("is_double", exp_r.is_double, got.is_double);
      compare_field("ku_row", exp_r.ku_row, got.ku_row);
      compare_field("ten_cell", exp_r.ten_cell, got.ten_cell);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] sjis_code_o;
  logic [15:0] jis_code_o;
  logic [15:0] euc_code_o;
  logic        is_double_o;
  logic [6:0]  ku_row_o;
  logic [6:0]  ten_cell_o;

  sjis_char_scoreboard sb = new();
  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  bit                  hold_active;
  event                hold_start;

  sjis_char_code_decoder_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sjis_code_o (sjis_code_o),
    .jis_code_o  (jis_code_o),
    .euc_code_o  (euc_code_o),
    .is_double_o (is_double_o),
    .ku_row_o    (ku_row_o),
    .ten_cell_o  (ten_cell_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_active) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    forever begin
      @(hold_start);
      hold_active = 1'b1;
      repeat (300) @(posedge clk_i);
      hold_active = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.sjis_code = sjis_code_o;
        got.jis_code  = jis_code_o;
        got.euc_code  = euc_code_o;
        got.is_double = is_double_o;
        got.ku_row    = ku_row_o;
        got.ten_cell  = ten_cell_o;
        sb.check_result(got);
      end
      if (in_valid_i && in_ready_o) sb.note_byte(in_byte_i);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_for_drain();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [7:0]  b;
    logic [7:0]  t;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      b = $urandom_range(0, 1) ? 8'($urandom_range(8'h81, 8'h9F))
                               : 8'($urandom_range(8'hE0, 8'hFC));
      do t = 8'($urandom_range(8'h40, 8'hFC)); while (t == 8'h7F);
      send_byte(b);
      send_byte(t);
    end else if (pick < 85) begin
      do b = 8'($urandom_range(1, 255)); while (sb.starts_double(b));
      send_byte(b);
    end else if (pick < 90) begin
      send_byte(8'h00);
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [7:0]  directed[$];
    int unsigned phase;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_byte_i      = 8'h00;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pairs at the table corners, user-defined leads, broken pairs and a lost lead.
    directed = '{8'h41, 8'h81, 8'h40, 8'h9F, 8'hFC, 8'hE0, 8'h40, 8'hFC, 8'hFC,
                 8'h88, 8'h7E, 8'h88, 8'h80, 8'hF0, 8'h9E, 8'h81, 8'h7F,
                 8'h84, 8'h85, 8'hE5, 8'h20, 8'h86, 8'h00, 8'hA1, 8'hFE,
                 8'hFF, 8'h80, 8'hA0, 8'hDF, 8'h00, 8'h01, 8'h9E, 8'hFD};
    foreach (directed[i]) send_byte(directed[i]);
    wait_for_drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      if (phase == 0) begin
        -> hold_start;
        for (int k = 0; k < 64; k++) send_byte(8'h20 + 8'(k));
      end
      for (int n = 0; n < 100; n++) send_random_item();
      wait_for_drain();
    end

    wait_for_drain();
    repeat (10) @(posedge clk_i);

    if (sb.expected_q.size() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, sb.expected_q.size());
      sb.errors++;
    end
    $display("Run covered %0d bytes and %0d characters (%0d two-byte),",
             sb.bytes_seen, sb.chars_checked, sb.double_chars);
    $display("with broken pairs, end-of-string bytes and idle and stall phases.");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/sjisdec_pkg.sv
design/sjisdec_in_stage.sv
design/sjisdec_convert.sv
design/sjisdec_out_stage.sv
design/sjis_char_code_decoder_unit.sv
design/sjisdec_checker.sv
test/sjis_char_code_decoder_unit_test.sv
